[hdl/keyed_latency_stats_table_top_defines.svh]
// Assertion macros shared by the statistics table RTL.
// Depends on nothing; included by the files that carry concurrent assertions.
`ifndef KEYED_LATENCY_STATS_TABLE_TOP_DEFINES_SVH
`define KEYED_LATENCY_STATS_TABLE_TOP_DEFINES_SVH

// The condition must hold at every clock edge outside reset.
`define KLST_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// When the antecedent holds, the consequent must hold at the following clock edge.
`define KLST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/klst_pkg.sv]
// Types, codes and constants of the keyed latency statistics table.
// No dependencies; imported by the divider and the top level.
`timescale 1ns / 1ps

package klst_pkg;

    localparam int MAX_ENTRIES_DEF   = 64;
    localparam int DURATION_BITS_DEF = 32;

    localparam int KEY_W      = 24;
    localparam int HIT_W      = 32;
    localparam int SUM_W      = 48;
    localparam int TICK_W     = 32;
    localparam int OUT_IDX_W  = 6;
    localparam int READ_IDX_W = 6;

    typedef enum logic [1:0] {
        CMD_RECORD = 2'd0,
        CMD_READ   = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_UNUSED = 2'd3
    } t_command;

    typedef enum logic [2:0] {
        STAT_UPDATED    = 3'd0,
        STAT_NEW_ENTRY  = 3'd1,
        STAT_FULL       = 3'd2,
        STAT_READ_OK    = 3'd3,
        STAT_READ_EMPTY = 3'd4,
        STAT_CLEARED    = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_RDWAIT,
        ST_DIVGO,
        ST_DIV,
        ST_FINISH
    } t_state;

    typedef struct packed {
        t_command                command;
        logic [7:0]              table_id;
        logic [7:0]              operation_kind;
        logic [7:0]              sub_kind;
        logic [TICK_W-1:0]       duration_ticks;
        logic [READ_IDX_W-1:0]   read_index;
    } t_in_word;

    typedef struct packed {
        t_status                 status;
        logic [OUT_IDX_W-1:0]    entry_index;
        logic [7:0]              entry_table;
        logic [7:0]              entry_operation;
        logic [7:0]              entry_sub;
        logic [HIT_W-1:0]        hit_count;
        logic [TICK_W-1:0]       average_ticks;
        logic [TICK_W-1:0]       maximum_ticks;
    } t_out_word;

endpackage

[hdl/klst_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies; holds the entry records of the statistics table.
`timescale 1ns / 1ps

module klst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hdl/klst_div.sv]
// Serial restoring divider, one quotient bit per cycle.
// Depends on klst_pkg for its default widths.
`timescale 1ns / 1ps

module klst_div #(
    parameter int DVD_W = klst_pkg::SUM_W,
    parameter int DVS_W = klst_pkg::HIT_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_busy,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);

    import klst_pkg::*;

    localparam int STEP_W = $clog2(DVD_W + 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_step, n_step;
    logic [DVS_W-1:0]  r_rem,  n_rem;
    logic [DVS_W-1:0]  r_dvs,  n_dvs;
    logic [DVD_W-1:0]  r_quo,  n_quo;

    logic [DVS_W:0] w_rem_sh;
    logic [DVS_W:0] w_diff;

    // The partial remainder stays below the divisor, so one extra bit suffices.
    assign w_rem_sh = {r_rem, r_quo[DVD_W-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_quo  = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = STEP_W'(DVD_W);
            n_rem  = '0;
            n_dvs  = i_divisor;
            n_quo  = i_dividend;
        end else if (r_busy) begin
            if (w_rem_sh >= {1'b0, r_dvs}) begin
                n_rem = w_diff[DVS_W-1:0];
                n_quo = {r_quo[DVD_W-2:0], 1'b1};
            end else begin
                n_rem = w_rem_sh[DVS_W-1:0];
                n_quo = {r_quo[DVD_W-2:0], 1'b0};
            end
            n_step = r_step - STEP_W'(1);
            if (r_step == STEP_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dvs <= n_dvs;
        r_quo <= n_quo;
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[hdl/keyed_latency_stats_table_top.sv]
// Top level of the keyed latency statistics table: sequencer, entry RAM and divider.
// Depends on klst_pkg, klst_ram, klst_div and the assertion macro header.
//
// One input word is processed at a time; the input stalls from acceptance until the
// result word is placed in the output register. A record word scans the used entries
// one per cycle through the single read port of the entry RAM, then writes the entry
// back and runs the serial division for the average. A read word that hits an entry
// runs the same divider. Clear, unused commands, reads of an empty slot and records
// dropped on a full table skip the divider. A finished result waits in the output
// register while the next word is accepted. Clearing only resets the fill count, so
// reset needs no clearing pass.
`timescale 1ns / 1ps
`include "keyed_latency_stats_table_top_defines.svh"

module keyed_latency_stats_table_top #(
    parameter int MAX_ENTRIES   = klst_pkg::MAX_ENTRIES_DEF,
    parameter int DURATION_BITS = klst_pkg::DURATION_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  klst_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output klst_pkg::t_out_word o_out_word
);

    import klst_pkg::*;

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int ENT_W = KEY_W + HIT_W + SUM_W + DURATION_BITS;

    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_used, n_used;
    logic [CNT_W-1:0]         r_idx, n_idx;
    logic                     r_pend, n_pend;
    logic [IDX_W-1:0]         r_cmp_idx, n_cmp_idx;
    logic [KEY_W-1:0]         r_key, n_key;
    logic [DURATION_BITS-1:0] r_dur, n_dur;
    logic [IDX_W-1:0]         r_eidx, n_eidx;
    t_status                  r_status, n_status;
    logic [HIT_W-1:0]         r_cnt, n_cnt;
    logic [SUM_W-1:0]         r_sum, n_sum;
    logic [DURATION_BITS-1:0] r_max, n_max;
    t_out_word                r_res, n_res;
    logic                     r_out_valid, n_out_valid;
    t_out_word                r_out_word;

    logic                     w_out_load;
    logic                     w_rd_en;
    logic [IDX_W-1:0]         w_rd_addr;
    logic                     w_wr_en;
    logic [ENT_W-1:0]         w_rd_data;
    logic [KEY_W-1:0]         w_rd_key;
    logic [HIT_W-1:0]         w_rd_cnt;
    logic [SUM_W-1:0]         w_rd_sum;
    logic [DURATION_BITS-1:0] w_rd_max;
    logic [SUM_W:0]           w_sum_add;
    logic [KEY_W-1:0]         w_in_key;
    logic [IDX_W+5:0]         w_ridx_ext;
    logic [IDX_W+5:0]         w_eidx_ext;
    logic                     w_ridx_ok;
    logic                     w_div_start;
    logic                     w_div_busy;
    logic                     w_div_done;
    logic [SUM_W-1:0]         w_quotient;

    klst_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_eidx),
        .i_wr_data ({r_key, r_cnt, r_sum, r_max}),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    klst_div #(
        .DVD_W (SUM_W),
        .DVS_W (HIT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_cnt),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    assign {w_rd_key, w_rd_cnt, w_rd_sum, w_rd_max} = w_rd_data;
    assign w_sum_add  = {1'b0, w_rd_sum} + (SUM_W + 1)'(r_dur);
    assign w_in_key   = {i_in_word.table_id, i_in_word.operation_kind, i_in_word.sub_kind};
    assign w_ridx_ext = (IDX_W + 6)'(i_in_word.read_index);
    assign w_eidx_ext = (IDX_W + 6)'(r_eidx);
    assign w_ridx_ok  = (CNT_W + 6)'(i_in_word.read_index) < (CNT_W + 6)'(r_used);

    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_cmp_idx   = r_cmp_idx;
        n_key       = r_key;
        n_dur       = r_dur;
        n_eidx      = r_eidx;
        n_status    = r_status;
        n_cnt       = r_cnt;
        n_sum       = r_sum;
        n_max       = r_max;
        n_res       = r_res;
        w_out_load  = 1'b0;
        w_rd_en     = 1'b0;
        w_rd_addr   = '0;
        w_wr_en     = 1'b0;
        w_div_start = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_word.command)
                        CMD_RECORD: begin
                            n_key   = w_in_key;
                            n_dur   = i_in_word.duration_ticks[DURATION_BITS-1:0];
                            n_idx   = '0;
                            n_pend  = 1'b0;
                            n_state = ST_SCAN;
                        end
                        CMD_READ: begin
                            n_eidx = w_ridx_ext[IDX_W-1:0];
                            if (w_ridx_ok) begin
                                w_rd_en   = 1'b1;
                                w_rd_addr = w_ridx_ext[IDX_W-1:0];
                                n_status  = STAT_READ_OK;
                                n_state   = ST_RDWAIT;
                            end else begin
                                n_res             = '0;
                                n_res.status      = STAT_READ_EMPTY;
                                n_res.entry_index = i_in_word.read_index;
                                n_state           = ST_FINISH;
                            end
                        end
                        CMD_CLEAR: begin
                            n_used       = '0;
                            n_res        = '0;
                            n_res.status = STAT_CLEARED;
                            n_state      = ST_FINISH;
                        end
                        default: begin
                            n_res        = '0;
                            n_res.status = STAT_READ_EMPTY;
                            n_state      = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // Reads are issued one entry ahead; the compare looks at the previous read.
                if (r_pend && (w_rd_key == r_key)) begin
                    n_pend   = 1'b0;
                    n_eidx   = r_cmp_idx;
                    n_status = STAT_UPDATED;
                    n_cnt    = (w_rd_cnt == '1) ? w_rd_cnt : w_rd_cnt + HIT_W'(1);
                    n_sum    = w_sum_add[SUM_W] ? '1 : w_sum_add[SUM_W-1:0];
                    n_max    = (r_dur > w_rd_max) ? r_dur : w_rd_max;
                    n_state  = ST_WRITE;
                end else if (r_idx < r_used) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_idx[IDX_W-1:0];
                    n_cmp_idx = r_idx[IDX_W-1:0];
                    n_idx     = r_idx + CNT_W'(1);
                    n_pend    = 1'b1;
                end else if (r_pend) begin
                    n_pend = 1'b0;
                end else if (r_used == CNT_W'(MAX_ENTRIES)) begin
                    n_res                 = '0;
                    n_res.status          = STAT_FULL;
                    n_res.entry_table     = r_key[23:16];
                    n_res.entry_operation = r_key[15:8];
                    n_res.entry_sub       = r_key[7:0];
                    n_state               = ST_FINISH;
                end else begin
                    n_eidx   = r_used[IDX_W-1:0];
                    n_status = STAT_NEW_ENTRY;
                    n_cnt    = HIT_W'(1);
                    n_sum    = SUM_W'(r_dur);
                    n_max    = r_dur;
                    n_used   = r_used + CNT_W'(1);
                    n_state  = ST_WRITE;
                end
            end
            ST_WRITE: begin
                w_wr_en = 1'b1;
                n_state = ST_DIVGO;
            end
            ST_RDWAIT: begin
                n_key   = w_rd_key;
                n_cnt   = w_rd_cnt;
                n_sum   = w_rd_sum;
                n_max   = w_rd_max;
                n_state = ST_DIVGO;
            end
            ST_DIVGO: begin
                w_div_start = 1'b1;
                n_state     = ST_DIV;
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_res.status          = r_status;
                    n_res.entry_index     = w_eidx_ext[OUT_IDX_W-1:0];
                    n_res.entry_table     = r_key[23:16];
                    n_res.entry_operation = r_key[15:8];
                    n_res.entry_sub       = r_key[7:0];
                    n_res.hit_count       = r_cnt;
                    n_res.average_ticks   = w_quotient[TICK_W-1:0];
                    n_res.maximum_ticks   = TICK_W'(r_max);
                    n_state               = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (w_out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_used      <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_idx       <= n_idx;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= n_cmp_idx;
        r_key     <= n_key;
        r_dur     <= n_dur;
        r_eidx    <= n_eidx;
        r_status  <= n_status;
        r_cnt     <= n_cnt;
        r_sum     <= n_sum;
        r_max     <= n_max;
        r_res     <= n_res;
        if (w_out_load) begin
            r_out_word <= r_res;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `KLST_ASSERT_ALWAYS(a_used_bound, i_clk, i_rst_n, r_used <= CNT_W'(MAX_ENTRIES), "fill count exceeds table depth")
    `KLST_ASSERT_ALWAYS(a_scan_bound, i_clk, i_rst_n, (r_state != ST_SCAN) || (r_idx <= r_used), "scan index ran past the used entries")
    `KLST_ASSERT_ALWAYS(a_div_free, i_clk, i_rst_n, !w_div_start || !w_div_busy, "divider started while busy")
    `KLST_ASSERT_NEXT(a_div_finish, i_clk, i_rst_n, (r_state == ST_DIV) && w_div_done, r_state == ST_FINISH, "division result not taken")

endmodule
